>>> sv/sle_pkg.sv
package sle_pkg;

	// Event codes, also used as the command codes passed from front to back.
	typedef enum logic [2:0] {
		EV_IGNORED   = 3'd0,
		EV_STORED    = 3'd1,
		EV_BACKSPACE = 3'd2,
		EV_RECALLED  = 3'd3,
		EV_LINE_CR   = 3'd4,
		EV_LINE_OVF  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SINGLE,
		BK_EMIT,
		BK_COPY
	} back_state_t;

	localparam logic [7:0] CH_BS       = 8'd8;
	localparam logic [7:0] CH_CR       = 8'd13;
	localparam logic [7:0] CH_ESC      = 8'd27;
	localparam logic [7:0] CH_LBRACKET = 8'd91;
	localparam logic [7:0] CH_UP       = 8'd65;
	localparam logic [7:0] CH_PRINT_LO = 8'd32;
	localparam logic [7:0] CH_PRINT_HI = 8'd126;

	localparam int OP_W       = 3;
	localparam int CHAR_W     = 8;
	localparam int FIELD5_W   = 5;
	localparam int OUT_DATA_W = 24;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

endpackage

>>> sv/serial_line_editor_with_recall_unit.sv
// Line editor for a received serial byte stream with one-line recall. Each
// accepted byte is classified at once and queued as a command in a four-entry
// queue, so bytes are taken back to back until the queue fills (after four
// bytes while the back end is busy); the back end then works through the
// queue. A byte that yields one result is handled as a queue pop and then
// the result. A line ending (CR or full line) is sent one character per
// cycle from the line memory's single read port while the output is not
// stalled, and an empty line gives a single result. An arrow-up recall
// copies the saved line into the edit line one character per cycle, and
// output back-pressure holds the line and result output. No clearing
// pass follows reset. Output tdata bits from the lowest: event_res[2:0],
// line_byte[10:3], byte_index[15:11], line_length[20:16], zeros above.
module serial_line_editor_with_recall_unit #(
	parameter int LINE_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // event_res, line_byte, byte_index, line_length
	output logic        m_axis_tlast
);
	import sle_pkg::*;

	localparam int CW    = $clog2(LINE_BYTES);
	localparam int CMD_W = OP_W + CHAR_W + CW;

	logic          cmd_valid;
	logic          cmd_ready;
	op_t           cmd_op;
	logic [7:0]    cmd_char;
	logic [CW-1:0] cmd_len;

	logic             q_valid;
	logic             q_pop;
	logic [CMD_W-1:0] q_data;
	op_t              q_op;

	logic [2:0] out_event;
	logic [7:0] out_char;
	logic [4:0] out_index;
	logic [4:0] out_length;

	sle_front #(
		.LINE_BYTES(LINE_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_char  (s_axis_tdata),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_op   (cmd_op),
		.cmd_char (cmd_char),
		.cmd_len  (cmd_len)
	);

	sle_queue #(
		.W(CMD_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(cmd_valid),
		.wr_ready(cmd_ready),
		.wr_data ({cmd_op, cmd_char, cmd_len}),
		.rd_valid(q_valid),
		.rd_pop  (q_pop),
		.rd_data (q_data)
	);

	assign q_op = op_t'(q_data[CMD_W-1 -: OP_W]);

	sle_back #(
		.LINE_BYTES(LINE_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_op      (q_op),
		.q_char    (q_data[CW +: CHAR_W]),
		.q_len     (q_data[CW-1:0]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_event (out_event),
		.out_char  (out_char),
		.out_index (out_index),
		.out_length(out_length),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {3'd0, out_length, out_index, out_char, out_event};

	// Single-result events always close their request.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (out_event == EV_IGNORED || out_event == EV_STORED
			|| out_event == EV_BACKSPACE || out_event == EV_RECALLED) |-> m_axis_tlast)
		else $error("single-result event without tlast");

	// Only line events carry character data or a position.
	a_single_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (out_event == EV_IGNORED || out_event == EV_STORED
			|| out_event == EV_BACKSPACE || out_event == EV_RECALLED)
			|-> (out_char == 8'd0 && out_index == 5'd0))
		else $error("non-line event carries line data");

	// Within a line, the position advances by one from each taken result to the next.
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast
			&& (out_event == EV_LINE_CR || out_event == EV_LINE_OVF)
			##1 m_axis_tvalid |-> out_index == $past(out_index) + 5'd1)
		else $error("line position skipped or repeated");

	// The back end pops the queue only when the queue holds a command.
	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("back end popped an empty queue");

endmodule

>>> sv/sle_front.sv
module sle_front #(
	parameter int LINE_BYTES = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      in_char,
	output logic                            cmd_valid,
	input  logic                            cmd_ready,
	output sle_pkg::op_t                    cmd_op,
	output logic [7:0]                      cmd_char,
	output logic [$clog2(LINE_BYTES)-1:0]   cmd_len
);
	import sle_pkg::*;

	localparam int CW = $clog2(LINE_BYTES);
	localparam logic [CW-1:0] FULL_COUNT = CW'(LINE_BYTES - 1);

	logic [CW-1:0] line_count_q;
	logic [CW-1:0] saved_count_q;
	logic          saved_valid_q;
	logic [7:0]    prev_one_q;
	logic [7:0]    prev_two_q;

	logic [CW-1:0] line_count_d;
	logic [CW-1:0] saved_count_d;
	logic          saved_valid_d;
	logic          shift_hist;
	logic          accept;

	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;
	assign accept    = in_valid && cmd_ready;
	assign cmd_char  = in_char;

	// Priority follows the editor rules: CR, arrow up, backspace, full line, printable.
	always_comb begin
		cmd_op        = EV_IGNORED;
		cmd_len       = line_count_q;
		line_count_d  = line_count_q;
		saved_count_d = saved_count_q;
		saved_valid_d = saved_valid_q;
		shift_hist    = 1'b0;
		if (in_char == CH_CR) begin
			cmd_op        = EV_LINE_CR;
			cmd_len       = line_count_q;
			saved_count_d = line_count_q;
			saved_valid_d = 1'b1;
			line_count_d  = '0;
		end else if (prev_two_q == CH_ESC && prev_one_q == CH_LBRACKET && in_char == CH_UP
				&& saved_valid_q) begin
			cmd_op       = EV_RECALLED;
			cmd_len      = saved_count_q;
			line_count_d = saved_count_q;
		end else if (in_char == CH_BS) begin
			line_count_d = (line_count_q != '0) ? line_count_q - 1'b1 : line_count_q;
			cmd_op       = EV_BACKSPACE;
			cmd_len      = line_count_d;
			shift_hist   = 1'b1;
		end else if (line_count_q == FULL_COUNT) begin
			cmd_op       = EV_LINE_OVF;
			cmd_len      = line_count_q;
			line_count_d = '0;
		end else if (in_char >= CH_PRINT_LO && in_char <= CH_PRINT_HI) begin
			line_count_d = line_count_q + 1'b1;
			cmd_op       = EV_STORED;
			cmd_len      = line_count_d;
			shift_hist   = 1'b1;
		end else begin
			cmd_op     = EV_IGNORED;
			cmd_len    = line_count_q;
			shift_hist = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q  <= '0;
			saved_count_q <= '0;
			saved_valid_q <= 1'b0;
			prev_one_q    <= '0;
			prev_two_q    <= '0;
		end else if (accept) begin
			line_count_q  <= line_count_d;
			saved_count_q <= saved_count_d;
			saved_valid_q <= saved_valid_d;
			if (shift_hist) begin
				prev_two_q <= prev_one_q;
				prev_one_q <= in_char;
			end
		end
	end

endmodule

>>> sv/sle_queue.sv
module sle_queue #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_pop,
	output logic [W-1:0] rd_data
);
	import sle_pkg::*;

	logic [W-1:0]      entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign wr_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = entries_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= wr_data;
	end

endmodule

>>> sv/sle_back.sv
module sle_back #(
	parameter int LINE_BYTES = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  sle_pkg::op_t                  q_op,
	input  logic [7:0]                    q_char,
	input  logic [$clog2(LINE_BYTES)-1:0] q_len,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    out_event,
	output logic [7:0]                    out_char,
	output logic [4:0]                    out_index,
	output logic [4:0]                    out_length,
	output logic                          out_last
);
	import sle_pkg::*;

	localparam int CW = $clog2(LINE_BYTES);

	logic [7:0] line_mem  [LINE_BYTES];
	logic [7:0] saved_mem [LINE_BYTES];

	back_state_t state_q, state_d;
	op_t         op_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] idx_q, idx_d;
	logic [7:0]    line_rd_q;
	logic [7:0]    saved_rd_q;

	logic          out_valid_q;
	logic [2:0]    out_event_q;
	logic [7:0]    out_char_q;
	logic [4:0]    out_index_q;
	logic [4:0]    out_length_q;
	logic          out_last_q;

	logic          out_free;
	logic          idx_last;
	logic          is_line_op;
	logic [CW+4:0] len_ext;
	logic [CW+4:0] idx_ext;

	logic          line_we;
	logic [CW-1:0] line_waddr;
	logic [7:0]    line_wdata;
	logic          saved_we;
	logic          load_out;
	logic [2:0]    ld_event;
	logic [7:0]    ld_char;
	logic [4:0]    ld_index;
	logic          ld_last;

	assign out_free   = !out_valid_q || out_ready;
	assign idx_last   = (idx_q == len_q - 1'b1);
	assign is_line_op = (q_op == EV_LINE_CR) || (q_op == EV_LINE_OVF);
	assign len_ext    = {5'd0, len_q};
	assign idx_ext    = {5'd0, idx_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					if (is_line_op && q_len != '0) state_d = BK_EMIT;
					else if (q_op == EV_RECALLED && q_len != '0) state_d = BK_COPY;
					else state_d = BK_SINGLE;
				end
			end
			BK_SINGLE: begin
				if (out_free) state_d = BK_IDLE;
			end
			BK_EMIT: begin
				if (out_free && idx_last) state_d = BK_IDLE;
			end
			BK_COPY: begin
				if (idx_last) state_d = BK_SINGLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// The read address always follows the next index, so read data lines up with idx_q.
	always_comb begin
		q_pop      = 1'b0;
		idx_d      = idx_q;
		line_we    = 1'b0;
		line_waddr = idx_q;
		line_wdata = saved_rd_q;
		saved_we   = 1'b0;
		load_out   = 1'b0;
		ld_event   = op_q;
		ld_char    = '0;
		ld_index   = '0;
		ld_last    = 1'b1;
		case (state_q)
			BK_IDLE: begin
				q_pop = q_valid;
				idx_d = '0;
				if (q_valid && q_op == EV_STORED) begin
					line_we    = 1'b1;
					line_waddr = q_len - 1'b1;
					line_wdata = q_char;
				end
			end
			BK_SINGLE: begin
				load_out = out_free;
			end
			BK_EMIT: begin
				load_out = out_free;
				ld_char  = line_rd_q;
				ld_index = idx_ext[4:0];
				ld_last  = idx_last;
				saved_we = out_free && (op_q == EV_LINE_CR);
				if (out_free && !idx_last) idx_d = idx_q + 1'b1;
			end
			BK_COPY: begin
				line_we = 1'b1;
				if (!idx_last) idx_d = idx_q + 1'b1;
			end
			default: begin
				idx_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (q_pop) begin
			op_q  <= q_op;
			len_q <= q_len;
		end
		if (load_out) begin
			out_event_q  <= ld_event;
			out_char_q   <= ld_char;
			out_index_q  <= ld_index;
			out_length_q <= len_ext[4:0];
			out_last_q   <= ld_last;
		end
	end

	always_ff @(posedge clk) begin
		if (line_we) line_mem[line_waddr] <= line_wdata;
		line_rd_q <= line_mem[idx_d];
	end

	always_ff @(posedge clk) begin
		if (saved_we) saved_mem[idx_q] <= line_rd_q;
		saved_rd_q <= saved_mem[idx_d];
	end

	assign out_valid  = out_valid_q;
	assign out_event  = out_event_q;
	assign out_char   = out_char_q;
	assign out_index  = out_index_q;
	assign out_length = out_length_q;
	assign out_last   = out_last_q;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import sle_pkg::*;

	localparam int LINE_BYTES  = 32;
	localparam int WATCHDOG    = 4000;
	localparam int HOLD_CYCLES = 250;
	localparam int DRAIN_WAIT  = 64;
	localparam int PHASE_BYTES = 100;

	typedef struct {
		op_t        ev;
		logic [7:0] ch;
		logic [4:0] pos;
		logic [4:0] len;
		logic       fin;
	} result_t;

	typedef struct {
		logic [7:0] rx;
		int         reps;
		bit         fixed;
		op_t        ev;
		logic [4:0] len;
	} script_row_t;

	localparam result_t NO_FIXED = '{EV_IGNORED, 8'd0, 5'd0, 5'd0, 1'b0};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;

	// Editor state as the testbench sees it.
	logic [7:0] edit_line [LINE_BYTES];
	logic [4:0] edit_len = '0;
	logic [7:0] saved_line [LINE_BYTES];
	logic [4:0] saved_len = '0;
	logic       saved_ok = 1'b0;
	logic [7:0] prior_one = '0;
	logic [7:0] prior_two = '0;

	result_t     pending_results [$];
	script_row_t script [0:27];

	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int idle_count = 0;
	int mismatches = 0;
	int bytes_sent = 0;
	int results_seen = 0;
	int events_seen [6];

	serial_line_editor_with_recall_unit #(.LINE_BYTES(LINE_BYTES)) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void emit_line(input op_t ev, ref result_t res[$]);
		int n;
		n = edit_len;
		if (n == 0) begin
			res.push_back('{ev, 8'd0, 5'd0, 5'd0, 1'b1});
		end else begin
			for (int i = 0; i < n; i++)
				res.push_back('{ev, edit_line[i], i[4:0], n[4:0], (i == n - 1)});
		end
	endfunction

	// Applies one received byte to the editor state and lists the results it causes.
	function automatic void edit_rx_byte(input logic [7:0] b, ref result_t res[$]);
		if (b == CH_CR) begin
			saved_line = edit_line;
			saved_len = edit_len;
			saved_ok = 1'b1;
			emit_line(EV_LINE_CR, res);
			edit_len = '0;
		end else if (prior_two == CH_ESC && prior_one == CH_LBRACKET && b == CH_UP
				&& saved_ok) begin
			// History is left alone, so a further arrow key recalls again.
			edit_line = saved_line;
			edit_len = saved_len;
			res.push_back('{EV_RECALLED, 8'd0, 5'd0, edit_len, 1'b1});
		end else if (b == CH_BS) begin
			if (edit_len > 0)
				edit_len = edit_len - 1'b1;
			prior_two = prior_one;
			prior_one = b;
			res.push_back('{EV_BACKSPACE, 8'd0, 5'd0, edit_len, 1'b1});
		end else if (edit_len >= LINE_BYTES - 1) begin
			// A full line goes out unsaved and the byte is dropped.
			emit_line(EV_LINE_OVF, res);
			edit_len = '0;
		end else if (b >= CH_PRINT_LO && b <= CH_PRINT_HI) begin
			edit_line[edit_len] = b;
			edit_len = edit_len + 1'b1;
			prior_two = prior_one;
			prior_one = b;
			res.push_back('{EV_STORED, 8'd0, 5'd0, edit_len, 1'b1});
		end else begin
			prior_two = prior_one;
			prior_one = b;
			res.push_back('{EV_IGNORED, 8'd0, 5'd0, edit_len, 1'b1});
		end
	endfunction

	task automatic send_rx(input logic [7:0] b, input bit fixed_on, input result_t fixed);
		result_t res [$];
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		edit_rx_byte(b, res);
		if (fixed_on) begin
			res.delete();
			res.push_back(fixed);
		end
		foreach (res[i])
			pending_results.push_back(res[i]);
		bytes_sent++;
	endtask

	task automatic put(input logic [7:0] b);
		send_rx(b, 1'b0, NO_FIXED);
	endtask

	function automatic logic [7:0] printable();
		return 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
	endfunction

	task automatic drain();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(input int count);
		int start;
		int pick;
		int n;
		start = bytes_sent;
		while (bytes_sent - start < count) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				n = $urandom_range(0, 12);
				repeat (n) begin
					if ($urandom_range(9) == 0)
						put(CH_BS);
					else
						put(printable());
				end
				put(CH_CR);
			end else if (pick < 52) begin
				// Fill the line, and run past its end to force an overflow when extra bytes are drawn.
				n = LINE_BYTES - 1 - edit_len + $urandom_range(0, 3);
				repeat (n) put(printable());
				if ($urandom_range(1))
					put(CH_CR);
			end else if (pick < 72) begin
				put(CH_ESC);
				put(CH_LBRACKET);
				put(CH_UP);
				repeat ($urandom_range(0, 2)) put(CH_UP);
				repeat ($urandom_range(0, 4)) put(printable());
				if ($urandom_range(1))
					put(CH_CR);
			end else if (pick < 82) begin
				repeat ($urandom_range(1, 5)) put(CH_BS);
			end else if (pick < 88) begin
				put(CH_ESC);
				put(8'($urandom_range(0, 255)));
				put(CH_UP);
			end else begin
				repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
			end
		end
		s_tvalid <= 1'b0;
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_req = 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, nothing pending: tdata=%06h last=%0b",
					$realtime, m_tdata, m_tlast);
			end else begin
				want = pending_results.pop_front();
				if (want.fin)
					events_seen[want.ev]++;
				if (m_tdata[2:0] !== want.ev || m_tdata[10:3] !== want.ch
						|| m_tdata[15:11] !== want.pos || m_tdata[20:16] !== want.len
						|| m_tlast !== want.fin) begin
					mismatches++;
					$display({"%0t: mismatch: expected ev=%0d ch=%02h idx=%0d len=%0d",
						" last=%0b, got ev=%0d ch=%02h idx=%0d len=%0d last=%0b"},
						$realtime, want.ev, want.ch, want.pos, want.len, want.fin,
						m_tdata[2:0], m_tdata[10:3], m_tdata[15:11], m_tdata[20:16], m_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_count <= 0;
		end else if (idle_count + 1 >= WATCHDOG) begin
			$display("%0t: no request moved for %0d cycles", $realtime, WATCHDOG);
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_count <= idle_count + 1;
		end
	end

	initial begin
		int idle_tab [4];
		int stall_tab [4];
		int directed_bytes;
		idle_tab = '{0, 55, 0, 18};
		stall_tab = '{0, 0, 55, 18};
		script = '{
			'{8'h41,       1,  1, EV_STORED,    5'd1},   // arrow key letter before any saved line
			'{CH_BS,       1,  1, EV_BACKSPACE, 5'd0},
			'{CH_BS,       1,  1, EV_BACKSPACE, 5'd0},   // backspace on an empty line
			'{CH_CR,       1,  1, EV_LINE_CR,   5'd0},   // empty line
			'{8'h00,       1,  1, EV_IGNORED,   5'd0},
			'{8'hFF,       1,  1, EV_IGNORED,   5'd0},
			'{CH_PRINT_LO, 1,  1, EV_STORED,    5'd1},
			'{CH_PRINT_HI, 1,  1, EV_STORED,    5'd2},
			'{8'h1F,       1,  1, EV_IGNORED,   5'd2},
			'{8'h7F,       1,  1, EV_IGNORED,   5'd2},
			'{CH_CR,       1,  0, EV_LINE_CR,   5'd0},
			'{CH_ESC,      1,  1, EV_IGNORED,   5'd0},
			'{CH_LBRACKET, 1,  1, EV_STORED,    5'd1},
			'{CH_UP,       1,  1, EV_RECALLED,  5'd2},
			'{CH_UP,       1,  1, EV_RECALLED,  5'd2},   // repeated recall
			'{CH_BS,       1,  1, EV_BACKSPACE, 5'd1},
			'{CH_UP,       1,  1, EV_STORED,    5'd2},   // sequence broken by backspace
			'{8'h7A,       29, 0, EV_STORED,    5'd0},
			'{CH_BS,       1,  1, EV_BACKSPACE, 5'd30},  // backspace on a full line
			'{8'h79,       1,  1, EV_STORED,    5'd31},
			'{CH_CR,       1,  0, EV_LINE_CR,   5'd0},   // longest line saved
			'{CH_ESC,      1,  1, EV_IGNORED,   5'd0},
			'{CH_LBRACKET, 1,  1, EV_STORED,    5'd1},
			'{CH_UP,       1,  1, EV_RECALLED,  5'd31},
			'{CH_UP,       1,  1, EV_RECALLED,  5'd31},  // recall on a full line
			'{8'hC8,       1,  0, EV_LINE_OVF,  5'd0},   // full line, byte dropped
			'{CH_UP,       1,  1, EV_RECALLED,  5'd31},  // history survives the overflow
			'{CH_CR,       1,  0, EV_LINE_CR,   5'd0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			repeat (script[i].reps)
				send_rx(script[i].rx, script[i].fixed,
					'{script[i].ev, 8'd0, 5'd0, script[i].len, 1'b1});
		s_tvalid <= 1'b0;
		directed_bytes = bytes_sent;
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_tab[ph];
			stall_pct = stall_tab[ph];
			// With no idling the long hold-off fills the command queue.
			if (ph == 0)
				hold_req = 1'b1;
			random_phase(PHASE_BYTES);
			drain();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		$display("%0d bytes sent (%0d directed), %0d results checked", bytes_sent,
			directed_bytes, results_seen);
		$display({"requests by event: ignored %0d, stored %0d, backspace %0d,",
			" recalled %0d, CR lines %0d, overflow lines %0d"},
			events_seen[0], events_seen[1], events_seen[2], events_seen[3],
			events_seen[4], events_seen[5]);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> filelist.f
sv/sle_pkg.sv
sv/sle_front.sv
sv/sle_queue.sv
sv/sle_back.sv
sv/serial_line_editor_with_recall_unit.sv
bench/testbench.sv
